// ===== hw/rtl/voxel_face_culling_mesher_macros.svh =====
// ---------------------------------------------------------------------------
// Voxel face culling mesher assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ---------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULLING_MESHER_MACROS_SVH
`define VOXEL_FACE_CULLING_MESHER_MACROS_SVH

// Check cons in the same cycle as ante.
`define VFCM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define VFCM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/vfcm_pkg.sv =====
// ---------------------------------------------------------------------------
// Voxel face culling mesher package
// Shared field widths, operation and direction codes and payload types.
// ---------------------------------------------------------------------------
package vfcm_pkg;

	// Default geometry and stored field widths
	localparam int EdgeCellsDef = 16;
	localparam int KindBitsDef  = 16;
	localparam int LightBitsDef = 8;

	// Fixed port field widths
	localparam int CoordBits = 4;
	localparam int NbBits    = 5;
	localparam int KindW     = 16;
	localparam int LightW    = 8;
	localparam int DirBits   = 3;
	localparam int VertBits  = 17;
	localparam int CountBits = 15;
	localparam int CountMax  = 32767;

	// Operation codes
	localparam logic [1:0] OpWrite = 2'd0;
	localparam logic [1:0] OpMesh  = 2'd1;
	localparam logic [1:0] OpBegin = 2'd2;

	// Face direction codes, in emit order
	localparam logic [DirBits-1:0] DirXNeg = 3'd0;
	localparam logic [DirBits-1:0] DirXPos = 3'd1;
	localparam logic [DirBits-1:0] DirYNeg = 3'd2;
	localparam logic [DirBits-1:0] DirYPos = 3'd3;
	localparam logic [DirBits-1:0] DirZNeg = 3'd4;
	localparam logic [DirBits-1:0] DirZPos = 3'd5;

	typedef struct packed {
		logic [1:0]           operation;
		logic [CoordBits-1:0] cell_x;
		logic [CoordBits-1:0] cell_y;
		logic [CoordBits-1:0] cell_z;
		logic [KindW-1:0]     voxel_kind;
		logic [LightW-1:0]    voxel_light;
	} cmd_t;

	typedef struct packed {
		logic [CoordBits-1:0] face_x;
		logic [CoordBits-1:0] face_y;
		logic [CoordBits-1:0] face_z;
		logic [DirBits-1:0]   direction;
		logic [KindW-1:0]     face_kind;
		logic [LightW-1:0]    face_light;
		logic [VertBits-1:0]  first_vertex;
		logic                 last_face;
	} face_t;

	// Store access: write enable and cell coordinates with one carry bit
	typedef struct packed {
		logic              wr;
		logic [NbBits-1:0] x;
		logic [NbBits-1:0] y;
		logic [NbBits-1:0] z;
	} store_req_t;

endpackage

// ===== hw/rtl/voxel_face_culling_mesher.sv =====
// Write, begin and ignored commands leave busy low.
// A mesh command keeps busy high in StCell, then in StNb and StFlush unless
// the cell is air: one cell read, then one neighbor read per cycle from the
// single-port store. Faces leave in direction order, at most one per cycle.
// Reset clears the sequencer, face counter and air code; the store is not
// cleared. Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
// Voxel face culling mesher
// Stores a voxel chunk and emits the exposed faces of one cell per command.
// ---------------------------------------------------------------------------
module voxel_face_culling_mesher #(
	parameter int EDGE_CELLS = vfcm_pkg::EdgeCellsDef,
	parameter int KIND_BITS  = vfcm_pkg::KindBitsDef,
	parameter int LIGHT_BITS = vfcm_pkg::LightBitsDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  vfcm_pkg::cmd_t                 command,
	output logic                           face_strobe,
	output vfcm_pkg::face_t                face,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vfcm_pkg::KindW-1:0]     cfg_data
);

	localparam int DataBits  = KIND_BITS + LIGHT_BITS;
	localparam int CellCount = EDGE_CELLS * EDGE_CELLS * EDGE_CELLS;
	localparam int FaceRaw   = 6 * CellCount - 1;
	localparam int FaceCap   = (FaceRaw < vfcm_pkg::CountMax) ? FaceRaw : vfcm_pkg::CountMax;
	localparam logic [7:0] EdgeV = 8'(EDGE_CELLS);

	// Sequencer states
	localparam logic [1:0] StIdle  = 2'd0;
	localparam logic [1:0] StCell  = 2'd1;
	localparam logic [1:0] StNb    = 2'd2;
	localparam logic [1:0] StFlush = 2'd3;

	logic [1:0] state_q;
	logic [vfcm_pkg::DirBits-1:0] dir_q;
	logic [vfcm_pkg::CountBits-1:0] count_q;
	logic [vfcm_pkg::KindW-1:0] air_q;
	logic pend_v_q;
	logic out_v_q;

	logic [vfcm_pkg::CoordBits-1:0] cx_q, cy_q, cz_q;
	logic [KIND_BITS-1:0] kind_q;
	logic [LIGHT_BITS-1:0] light_q;
	vfcm_pkg::face_t pend_q;
	vfcm_pkg::face_t out_q;

	logic accept;
	logic in_inside;
	vfcm_pkg::store_req_t req;
	logic [DataBits-1:0] wdata;
	logic [DataBits-1:0] rdata;
	logic [vfcm_pkg::DirBits-1:0] rd_dir;
	logic [vfcm_pkg::NbBits-1:0] bx, by, bz;
	logic [KIND_BITS+vfcm_pkg::KindW-1:0] wkind_ext;
	logic [LIGHT_BITS+vfcm_pkg::LightW-1:0] wlight_ext;
	logic [KIND_BITS-1:0] rd_kind;
	logic [LIGHT_BITS-1:0] rd_light;
	logic rd_air;
	logic outside_nb;
	logic hit;
	logic [KIND_BITS+vfcm_pkg::KindW-1:0] okind_ext;
	logic [LIGHT_BITS+vfcm_pkg::LightW-1:0] olight_ext;
	vfcm_pkg::face_t new_face;
	vfcm_pkg::face_t tail_face;

	assign cfg_ready   = 1'b1;
	assign busy        = (state_q != StIdle);
	assign accept      = start && (state_q == StIdle);
	assign face_strobe = out_v_q;
	assign face        = out_q;

	// Range check of the commanded cell
	assign in_inside = ({4'b0, command.cell_x} < EdgeV) && ({4'b0, command.cell_y} < EdgeV)
		&& ({4'b0, command.cell_z} < EdgeV);

	// Fit write data to the stored widths
	assign wkind_ext  = {KIND_BITS'(0), command.voxel_kind};
	assign wlight_ext = {LIGHT_BITS'(0), command.voxel_light};
	assign wdata      = {wkind_ext[KIND_BITS-1:0], wlight_ext[LIGHT_BITS-1:0]};

	// Pick the neighbor to read next: first in the cell cycle, then one ahead
	assign rd_dir = (state_q == StCell) ? vfcm_pkg::DirXNeg : dir_q + 3'd1;

	always_comb begin
		bx = {1'b0, cx_q};
		by = {1'b0, cy_q};
		bz = {1'b0, cz_q};
		case (rd_dir)
			vfcm_pkg::DirXNeg: bx = {1'b0, cx_q} - 5'd1;
			vfcm_pkg::DirXPos: bx = {1'b0, cx_q} + 5'd1;
			vfcm_pkg::DirYNeg: by = {1'b0, cy_q} - 5'd1;
			vfcm_pkg::DirYPos: by = {1'b0, cy_q} + 5'd1;
			vfcm_pkg::DirZNeg: bz = {1'b0, cz_q} - 5'd1;
			vfcm_pkg::DirZPos: bz = {1'b0, cz_q} + 5'd1;
			default: ;
		endcase
	end

	// Store access: commanded cell while idle, else the next neighbor
	always_comb begin
		if (state_q == StIdle) begin
			req.wr = accept && (command.operation == vfcm_pkg::OpWrite) && in_inside;
			req.x  = {1'b0, command.cell_x};
			req.y  = {1'b0, command.cell_y};
			req.z  = {1'b0, command.cell_z};
		end else begin
			req.wr = 1'b0;
			req.x  = bx;
			req.y  = by;
			req.z  = bz;
		end
	end

	vfcm_store #(
		.EDGE_CELLS (EDGE_CELLS),
		.DATA_BITS  (DataBits)
	) u_store (
		.clk   (clk),
		.req   (req),
		.wdata (wdata),
		.rdata (rdata)
	);

	// Classify the entry read in the previous cycle
	assign rd_kind  = rdata[DataBits-1:LIGHT_BITS];
	assign rd_light = rdata[LIGHT_BITS-1:0];
	assign rd_air   = ({vfcm_pkg::KindW'(0), rd_kind} == {KIND_BITS'(0), air_q});

	// Chunk edge test for the neighbor being judged
	always_comb begin
		case (dir_q)
			vfcm_pkg::DirXNeg: outside_nb = (cx_q == 4'd0);
			vfcm_pkg::DirXPos: outside_nb = ({4'b0, cx_q} + 8'd1) >= EdgeV;
			vfcm_pkg::DirYNeg: outside_nb = (cy_q == 4'd0);
			vfcm_pkg::DirYPos: outside_nb = ({4'b0, cy_q} + 8'd1) >= EdgeV;
			vfcm_pkg::DirZNeg: outside_nb = (cz_q == 4'd0);
			vfcm_pkg::DirZPos: outside_nb = ({4'b0, cz_q} + 8'd1) >= EdgeV;
			default:           outside_nb = 1'b1;
		endcase
	end

	assign hit = (state_q == StNb) && (outside_nb || rd_air);

	// Build the face for the current direction
	assign okind_ext  = {vfcm_pkg::KindW'(0), kind_q};
	assign olight_ext = {vfcm_pkg::LightW'(0), light_q};
	always_comb begin
		new_face.face_x       = cx_q;
		new_face.face_y       = cy_q;
		new_face.face_z       = cz_q;
		new_face.direction    = dir_q;
		new_face.face_kind    = okind_ext[vfcm_pkg::KindW-1:0];
		new_face.face_light   = olight_ext[vfcm_pkg::LightW-1:0];
		new_face.first_vertex = {count_q, 2'b00};
		new_face.last_face    = 1'b0;
	end

	// Mark the held face as the last one of the cell
	always_comb begin
		tail_face           = pend_q;
		tail_face.last_face = 1'b1;
	end

	// Sequencer, face counter, air code and strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			dir_q    <= vfcm_pkg::DirXNeg;
			count_q  <= '0;
			air_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			// Strobe the held face when a newer one displaces it or at the flush
			out_v_q <= (hit || (state_q == StFlush)) && pend_v_q;
			if (cfg_valid) begin
				air_q <= cfg_data;
			end
			case (state_q)
				StIdle: begin
					if (accept && command.operation == vfcm_pkg::OpBegin) begin
						count_q <= '0;
					end
					if (accept && command.operation == vfcm_pkg::OpMesh && in_inside) begin
						state_q <= StCell;
					end
				end
				StCell: begin
					dir_q   <= vfcm_pkg::DirXNeg;
					state_q <= rd_air ? StIdle : StNb;
				end
				StNb: begin
					if (hit) begin
						pend_v_q <= 1'b1;
						if (count_q < vfcm_pkg::CountBits'(FaceCap)) begin
							count_q <= count_q + 15'd1;
						end
					end
					if (dir_q == vfcm_pkg::DirZPos) begin
						state_q <= StFlush;
					end else begin
						dir_q <= dir_q + 3'd1;
					end
				end
				StFlush: begin
					pend_v_q <= 1'b0;
					state_q  <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// Payload: cell capture, held face and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= command.cell_x;
			cy_q <= command.cell_y;
			cz_q <= command.cell_z;
		end
		if (state_q == StCell) begin
			kind_q  <= rd_kind;
			light_q <= rd_light;
		end
		if (hit) begin
			out_q  <= pend_q;
			pend_q <= new_face;
		end
		if (state_q == StFlush) begin
			out_q <= tail_face;
		end
	end

endmodule

// ===== hw/rtl/vfcm_store.sv =====
// ---------------------------------------------------------------------------
// Voxel store
// Single-port synchronous memory of kind and light, addressed by cell.
// ---------------------------------------------------------------------------
module vfcm_store #(
	parameter int EDGE_CELLS = vfcm_pkg::EdgeCellsDef,
	parameter int DATA_BITS  = vfcm_pkg::KindBitsDef + vfcm_pkg::LightBitsDef
) (
	input  logic                  clk,
	input  vfcm_pkg::store_req_t  req,
	input  logic [DATA_BITS-1:0]  wdata,
	output logic [DATA_BITS-1:0]  rdata
);

	localparam int CB    = $clog2(EDGE_CELLS);
	localparam int AW    = 3 * CB;
	localparam int Depth = 1 << AW;

	logic [DATA_BITS-1:0] mem [Depth];
	logic [CB+vfcm_pkg::NbBits-1:0] x_ext;
	logic [CB+vfcm_pkg::NbBits-1:0] y_ext;
	logic [CB+vfcm_pkg::NbBits-1:0] z_ext;
	logic [AW-1:0] addr;

	// Form the cell address as z, y, x fields of CB bits each
	assign x_ext = {CB'(0), req.x};
	assign y_ext = {CB'(0), req.y};
	assign z_ext = {CB'(0), req.z};
	assign addr  = {z_ext[CB-1:0], y_ext[CB-1:0], x_ext[CB-1:0]};

	// Write or read one entry per cycle; read data registered
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hw/rtl/vfcm_checker.sv =====
// ---------------------------------------------------------------------------
// Voxel face culling mesher port checker
// Watches command transfers and face strobes on the top-level ports.
// ---------------------------------------------------------------------------
`include "voxel_face_culling_mesher_macros.svh"

module vfcm_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input vfcm_pkg::cmd_t  command,
	input logic            face_strobe,
	input vfcm_pkg::face_t face
);

	logic plain_xfer;

	// Transfer of a command that emits no face
	assign plain_xfer = start && !busy && (command.operation != vfcm_pkg::OpMesh);

	`VFCM_ASSERT_NEXT(a_plain_idle, plain_xfer, !busy, "busy after a non-mesh command")
	`VFCM_ASSERT_NEXT(a_plain_quiet, plain_xfer, !face_strobe, "face after a non-mesh command")
	`VFCM_ASSERT_SAME(a_dir_range, face_strobe, face.direction <= vfcm_pkg::DirZPos, "bad direction")
	`VFCM_ASSERT_NEXT(a_last_ends, face_strobe && face.last_face, !face_strobe, "face after last")

endmodule

bind voxel_face_culling_mesher vfcm_checker u_vfcm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.command     (command),
	.face_strobe (face_strobe),
	.face        (face)
);

// ===== test/tb_voxel_face_culling_mesher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Voxel face culling mesher testbench
// Writes voxels into the chunk and meshes cells through the command port,
// predicting every exposed face. The prediction covers neighbor culling,
// chunk borders, the air code and counter saturation. Each strobed face is
// checked field by field against the oldest predicted face.
// ---------------------------------------------------------------------------
module tb_voxel_face_culling_mesher;
	import vfcm_pkg::*;

	localparam int CellCount      = EdgeCellsDef * EdgeCellsDef * EdgeCellsDef;
	localparam int FaceCap        = (6 * CellCount - 1 < CountMax) ? 6 * CellCount - 1 : CountMax;
	localparam logic [1:0] OpUnused = 2'd3;
	localparam int SettleCycles   = 12;
	localparam int CycleLimit     = 40000;
	localparam int PhaseItems     = 55;
	localparam int BurstMeshes    = 20;

	// Chunk contents, face counter and the faces still to come
	class face_ledger;
		logic [KindW-1:0]     air_code;
		logic [CountBits-1:0] faces_made;
		logic [KindW-1:0]     kinds [CellCount];
		logic [LightW-1:0]    lights [CellCount];
		bit                   written [CellCount];
		logic [DirBits-1:0]   dir_order [6];
		face_t                faces_due [$];
		int                   mismatch_count;

		function new();
			air_code = '0;
			faces_made = '0;
			mismatch_count = 0;
			foreach (written[i]) written[i] = 1'b0;
			dir_order = '{DirXNeg, DirXPos, DirYNeg, DirYPos, DirZNeg, DirZPos};
		endfunction

		function int cell_index(int x, int y, int z);
			return (z * EdgeCellsDef + y) * EdgeCellsDef + x;
		endfunction

		// A face is open when its neighbor lies outside the chunk or is air
		function bit face_open(int x, int y, int z, logic [DirBits-1:0] dir);
			case (dir)
				DirXNeg: x--;
				DirXPos: x++;
				DirYNeg: y--;
				DirYPos: y++;
				DirZNeg: z--;
				DirZPos: z++;
				default: ;
			endcase
			if (x < 0 || y < 0 || z < 0 ||
					x >= EdgeCellsDef || y >= EdgeCellsDef || z >= EdgeCellsDef)
				return 1'b1;
			return kinds[cell_index(x, y, z)] == air_code;
		endfunction

		function void note_command(cmd_t c);
			int         a;
			logic [5:0] open_mask;
			face_t      f;
			a = cell_index(c.cell_x, c.cell_y, c.cell_z);
			case (c.operation)
				OpBegin: faces_made = '0;
				OpWrite: begin
					kinds[a] = c.voxel_kind;
					lights[a] = c.voxel_light;
					written[a] = 1'b1;
				end
				OpMesh: begin
					if (kinds[a] != air_code) begin
						for (int i = 0; i < 6; i++)
							open_mask[i] = face_open(c.cell_x, c.cell_y, c.cell_z, dir_order[i]);
						// emit open faces in direction order; counter sticks at the cap
						for (int i = 0; i < 6; i++) begin
							if (open_mask[i]) begin
								f.face_x = c.cell_x;
								f.face_y = c.cell_y;
								f.face_z = c.cell_z;
								f.direction = dir_order[i];
								f.face_kind = kinds[a];
								f.face_light = lights[a];
								f.first_vertex = {faces_made, 2'b00};
								f.last_face = ((open_mask >> (i + 1)) == 6'd0);
								faces_due.insert(faces_due.size(), f);
								if (faces_made < FaceCap)
									faces_made++;
							end
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatch_count++;
				$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			end
		endfunction

		function void check_face(face_t f);
			face_t e;
			if (faces_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: face expected none, got %h", $time, f);
				return;
			end
			e = faces_due.pop_front();
			compare("face_x", e.face_x, f.face_x);
			compare("face_y", e.face_y, f.face_y);
			compare("face_z", e.face_z, f.face_z);
			compare("direction", e.direction, f.direction);
			compare("face_kind", e.face_kind, f.face_kind);
			compare("face_light", e.face_light, f.face_light);
			compare("first_vertex", e.first_vertex, f.first_vertex);
			compare("last_face", e.last_face, f.last_face);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	cmd_t             command;
	logic             face_strobe;
	face_t            face;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [KindW-1:0] cfg_data;

	face_ledger ledger = new();
	int         cycle_count = 0;
	int         items_sent = 0;
	bit         steady = 1'b0;

	voxel_face_culling_mesher dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.face_strobe(face_strobe),
		.face       (face),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Check each face in the cycle it is strobed
	always @(posedge clk) begin
		if (arst_n && face_strobe)
			ledger.check_face(face);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(logic [1:0] op, int x, int y, int z,
			logic [KindW-1:0] kind, logic [LightW-1:0] light);
		cmd_t c;
		c.operation = op;
		c.cell_x = CoordBits'(x);
		c.cell_y = CoordBits'(y);
		c.cell_z = CoordBits'(z);
		c.voxel_kind = kind;
		c.voxel_light = light;
		return c;
	endfunction

	function automatic cmd_t rand_cmd(logic [1:0] op);
		return make_cmd(op, $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 15), KindW'($urandom), LightW'($urandom));
	endfunction

	// Lean toward air so that faces open and close often
	function automatic logic [KindW-1:0] draw_kind();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return ledger.air_code;
			4: return '1;
			5: return '0;
			default: return KindW'($urandom);
		endcase
	endfunction

	// Cluster cells near the chunk borders so neighbors get reused
	function automatic int draw_coord();
		return ($urandom_range(0, 1) ? 0 : EdgeCellsDef - 3) + $urandom_range(0, 2);
	endfunction

	// Hold the command until the block takes it, then predict
	task automatic send(cmd_t c);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		command <= c;
		do @(posedge clk); while (busy);
		ledger.note_command(c);
		items_sent++;
	endtask

	task automatic put(int x, int y, int z, logic [KindW-1:0] kind, logic [LightW-1:0] light);
		send(make_cmd(OpWrite, x, y, z, kind, light));
	endtask

	task automatic mesh(int x, int y, int z);
		send(make_cmd(OpMesh, x, y, z, KindW'($urandom), LightW'($urandom)));
	endtask

	// Write a cell if it is new, and now and then overwrite it
	task automatic fill_cell(int x, int y, int z);
		if (x < 0 || y < 0 || z < 0 ||
				x >= EdgeCellsDef || y >= EdgeCellsDef || z >= EdgeCellsDef)
			return;
		if (!ledger.written[ledger.cell_index(x, y, z)] || $urandom_range(0, 3) == 0)
			put(x, y, z, draw_kind(), LightW'($urandom));
	endtask

	// Make the cell and its neighbors valid, then mesh it
	task automatic mesh_seq(int x, int y, int z);
		fill_cell(x, y, z);
		fill_cell(x - 1, y, z);
		fill_cell(x + 1, y, z);
		fill_cell(x, y - 1, z);
		fill_cell(x, y + 1, z);
		fill_cell(x, y, z - 1);
		fill_cell(x, y, z + 1);
		mesh(x, y, z);
	endtask

	// Drop start and wait until every predicted face is out
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (ledger.faces_due.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_air(logic [KindW-1:0] code);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= code;
		do @(posedge clk); while (!cfg_ready);
		ledger.air_code = code;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(logic [KindW-1:0] code);
		int stop;
		int pick;
		set_air(code);
		stop = items_sent + PhaseItems;
		while (items_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				mesh_seq(draw_coord(), draw_coord(), draw_coord());
			else if (pick < 78)
				put($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
					draw_kind(), LightW'($urandom));
			else if (pick < 85)
				send(rand_cmd(OpBegin));
			else if (pick < 92)
				send(rand_cmd(OpUnused));
			else if (pick < 96)
				mesh_seq($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
			else
				settle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Lone corner cell: all six faces open
		send(rand_cmd(OpBegin));
		put(0, 0, 0, '1, '1);
		put(1, 0, 0, '0, '0);
		put(0, 1, 0, '0, '0);
		put(0, 0, 1, '0, '0);
		mesh(0, 0, 0);
		// air cell and unknown operation: nothing
		mesh(1, 0, 0);
		send(rand_cmd(OpUnused));
		// far corner: outside on the plus side, mixed neighbors
		put(15, 15, 15, 16'h0001, 8'h00);
		put(14, 15, 15, 16'h5555, 8'h80);
		put(15, 14, 15, '0, 8'h7f);
		put(15, 15, 14, 16'haaaa, 8'h01);
		mesh(15, 15, 15);
		// fully enclosed cell: no faces
		put(8, 8, 8, 16'h00f0, 8'h33);
		put(7, 8, 8, 16'h0002, 8'h10);
		put(9, 8, 8, 16'h0003, 8'h20);
		put(8, 7, 8, 16'h0004, 8'h40);
		put(8, 9, 8, 16'h0005, 8'h08);
		put(8, 8, 7, 16'h0006, 8'h04);
		put(8, 8, 9, 16'h0007, 8'h02);
		mesh(8, 8, 8);
		// restart the counter
		send(rand_cmd(OpBegin));
		mesh(0, 0, 0);
		// all-ones air code turns the corner into air
		set_air('1);
		mesh(0, 0, 0);
		mesh(8, 8, 8);

		// Mesh one exposed cell back to back
		set_air('0);
		send(rand_cmd(OpBegin));
		put(0, 0, 0, 16'h0bad, 8'hc5);
		steady = 1'b1;
		repeat (BurstMeshes) mesh(0, 0, 0);
		steady = 1'b0;
		send(rand_cmd(OpBegin));
		mesh(0, 0, 0);

		random_phase('1);
		steady = 1'b1;
		random_phase(KindW'($urandom));
		steady = 1'b0;
		random_phase(16'h0001);
		random_phase('0);

		settle();
		if (ledger.mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
